FILE: rtl/core/gtg_pkg.sv
// Package: widths, reset values, register indexes and the CORDIC atan table.
`timescale 1ns / 1ps
package gtg_pkg;
  localparam int FracBitsDef = 16;
  localparam int CordicStagesDef = 16;
  localparam int AtanEntries = 24;
  localparam logic [29:0] GainQ30 = 30'd652032874;

  localparam logic [20:0] LinGainRst = 21'd19661;
  localparam logic [21:0] AngGainRst = 22'd393216;
  localparam logic [19:0] MaxLinRst = 20'd14418;
  localparam logic [20:0] MaxAngRst = 21'd186122;
  localparam logic [19:0] StopDistRst = 20'd16384;

  typedef enum logic [2:0] {
    REG_LIN_GAIN = 3'd0,
    REG_ANG_GAIN = 3'd1,
    REG_MAX_LIN = 3'd2,
    REG_MAX_ANG = 3'd3,
    REG_STOP_DIST = 3'd4
  } reg_idx_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd843314857;
        5'd1: r = 32'd497837829;
        5'd2: r = 32'd263043837;
        5'd3: r = 32'd133525159;
        5'd4: r = 32'd67021687;
        5'd5: r = 32'd33543516;
        5'd6: r = 32'd16775851;
        5'd7: r = 32'd8388437;
        5'd8: r = 32'd4194283;
        5'd9: r = 32'd2097149;
        5'd10: r = 32'd1048576;
        5'd11: r = 32'd524288;
        5'd12: r = 32'd262144;
        5'd13: r = 32'd131072;
        5'd14: r = 32'd65536;
        5'd15: r = 32'd32768;
        5'd16: r = 32'd16384;
        5'd17: r = 32'd8192;
        5'd18: r = 32'd4096;
        5'd19: r = 32'd2048;
        5'd20: r = 32'd1024;
        5'd21: r = 32'd512;
        5'd22: r = 32'd256;
        5'd23: r = 32'd128;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage

FILE: rtl/core/go_to_goal_p_controller.sv
// Go-to-goal drive controller: pipelined CORDIC distance/bearing and P gains.
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in_     | in  | in_valid/in_ready    | leader_x/y, own_x/y, own_heading
// out_    | out | out_valid/out_ready  | linear_speed, angular_speed
// cfg_    | in  | cfg_we               | cfg_index, cfg_data
// One request per cycle sustained unless a stall holds the output. A request passes
// CORDIC_STAGES + 6 register stages (CORDIC_STAGES capped at 24): offset, fold, one per
// micro-rotation, distance product, rounding, gain multiply, clamp; the first is loaded
// at the accept edge. All stages advance together when the output stage is empty or
// being taken, so a stall holds every stage in place. Reset (synchronous) clears valid
// bits and loads the default gains.
module go_to_goal_p_controller import gtg_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_leader_x,
  input  logic signed [31:0] in_leader_y,
  input  logic signed [31:0] in_own_x,
  input  logic signed [31:0] in_own_y,
  input  logic signed [18:0] in_own_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [19:0] out_linear_speed,
  output logic signed [21:0] out_angular_speed,
  input  logic               cfg_we,
  input  logic         [2:0] cfg_index,
  input  logic        [21:0] cfg_data
);
  localparam int NS = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int NP = NS + 6;
  // x grows by at most 1.65x of |(dx,dy)| < 2^33.5; 36 bits with sign is enough
  localparam int XW = 37;

  logic [20:0] lin_gain_r;
  logic [21:0] ang_gain_r;
  logic [19:0] max_lin_r;
  logic [20:0] max_ang_r;
  logic [19:0] stop_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= LinGainRst;
      ang_gain_r <= AngGainRst;
      max_lin_r <= MaxLinRst;
      max_ang_r <= MaxAngRst;
      stop_dist_r <= StopDistRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIN_GAIN: lin_gain_r <= cfg_data[20:0];
        REG_ANG_GAIN: ang_gain_r <= cfg_data;
        REG_MAX_LIN: max_lin_r <= cfg_data[19:0];
        REG_MAX_ANG: max_ang_r <= cfg_data[20:0];
        REG_STOP_DIST: stop_dist_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  logic [NP-1:0] vld_r;
  logic adv;
  assign adv = !vld_r[NP-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[NP-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NP-2:0], in_valid};
  end

  // stage 0: offset
  logic signed [32:0] dx0_r, dy0_r;
  logic signed [18:0] hd_r [NS+2];
  logic dz_r [NS+2];
  always_ff @(posedge clk) begin
    if (adv) begin
      dx0_r <= 33'(in_leader_x) - 33'(in_own_x);
      dy0_r <= 33'(in_leader_y) - 33'(in_own_y);
      hd_r[0] <= in_own_heading;
      dz_r[0] <= (in_leader_x == in_own_x);
      for (int k = 1; k < NS + 2; k++) begin
        hd_r[k] <= hd_r[k-1];
        dz_r[k] <= dz_r[k-1];
      end
    end
  end

  // stage 1: fold; stages 2..NS+1: micro-rotations
  logic signed [XW-1:0] cx_r [NS+1];
  logic signed [XW-1:0] cy_r [NS+1];
  logic signed [33:0] cz_r [NS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= dx0_r[32] ? -XW'(dx0_r) : XW'(dx0_r);
      cy_r[0] <= dx0_r[32] ? -XW'(dy0_r) : XW'(dy0_r);
      cz_r[0] <= '0;
      for (int i = 0; i < NS; i++) begin
        if (!cy_r[i][XW-1]) begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + 34'(atan_q30(5'(i)));
        end else begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - 34'(atan_q30(5'(i)));
        end
      end
    end
  end

  // stage NS+2: distance product and bearing/error
  logic [66:0] dprod_r;
  logic signed [34:0] err_r;
  logic signed [33:0] zr;
  logic signed [33:0] bear;
  assign zr = cz_r[NS] + (34'sd1 <<< (29 - FRAC_BITS));
  // both arms signed so the shift stays arithmetic
  assign bear = dz_r[NS+1] ? 34'sd0 : (zr >>> (30 - FRAC_BITS));
  always_ff @(posedge clk) begin
    if (adv) begin
      dprod_r <= 67'(cx_r[NS][XW-2:0]) * 67'(GainQ30);
      err_r <= 35'(bear) - 35'(hd_r[NS+1]);
    end
  end

  // stage NS+3: round distance
  logic [36:0] dist_r;
  logic signed [34:0] err2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= 37'((dprod_r + (67'd1 << 29)) >> 30);
      err2_r <= err_r;
    end
  end

  // stage NS+4: gain products
  logic [57:0] vprod_r;
  logic signed [57:0] wprod_r;
  logic dlt_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      vprod_r <= 58'(dist_r) * 58'(lin_gain_r);
      wprod_r <= 58'(err2_r) * $signed({36'd0, ang_gain_r});
      dlt_r <= dist_r < 37'(stop_dist_r);
    end
  end

  // stage NS+5: round, clamp
  logic [57:0] v;
  logic signed [57:0] w;
  assign v = (vprod_r + (58'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign w = (wprod_r + (58'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (dlt_r) out_linear_speed <= '0;
      else if (v > 58'(max_lin_r)) out_linear_speed <= max_lin_r;
      else out_linear_speed <= v[19:0];
      if (w > $signed(58'(max_ang_r))) out_angular_speed <= 22'(max_ang_r);
      else if (w < -$signed(58'(max_ang_r))) out_angular_speed <= -22'(max_ang_r);
      else out_angular_speed <= w[21:0];
    end
  end
endmodule

FILE: tb/go_to_goal_p_controller_checker.sv
// Checker: predicts each drive command from the request and compares it with the result.
`timescale 1ns / 1ps
module go_to_goal_p_controller_checker import gtg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_leader_x,
  input  logic signed [31:0] in_leader_y,
  input  logic signed [31:0] in_own_x,
  input  logic signed [31:0] in_own_y,
  input  logic signed [18:0] in_own_heading,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [19:0] out_linear_speed,
  input  logic signed [21:0] out_angular_speed,
  input  logic               cfg_we,
  input  logic         [2:0] cfg_index,
  input  logic        [21:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);
  typedef struct packed {
    logic        [19:0] lin;
    logic signed [21:0] ang;
  } drive_cmd_t;

  localparam longint ATAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  logic [20:0] lin_gain;
  logic [21:0] ang_gain;
  logic [19:0] max_lin;
  logic [20:0] max_ang;
  logic [19:0] stop_dist;
  drive_cmd_t  cmd_q[$];

  function automatic drive_cmd_t drive_command(input logic signed [31:0] lx,
      input logic signed [31:0] ly, input logic signed [31:0] ox,
      input logic signed [31:0] oy, input logic signed [18:0] hd);
    longint dx, dy, x, y, z, xs, ys, bearing, err, omega, lim;
    longint unsigned dist_m, v;
    drive_cmd_t c;
    dx = longint'(lx) - longint'(ox);
    dy = longint'(ly) - longint'(oy);
    x = dx;
    y = dy;
    z = 0;
    // fold into the right half plane
    if (dx < 0) begin
      x = -dx;
      y = -dy;
    end
    for (int i = 0; i < CordicStagesDef && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q30[i];
      end
    end
    dist_m = (longint'(unsigned'(x)) * longint'(GainQ30) + (64'd1 << 29)) >> 30;
    v = (dist_m * lin_gain + (64'd1 << 15)) >> 16;
    if (v > max_lin) v = max_lin;
    if (dist_m < stop_dist) v = 0;
    bearing = (dx == 0) ? 0 : ((z + (64'sd1 <<< 13)) >>> 14);
    err = bearing - longint'(hd);
    omega = (err * longint'(ang_gain) + (64'sd1 <<< 15)) >>> 16;
    lim = longint'(max_ang);
    if (omega > lim) omega = lim;
    else if (omega < -lim) omega = -lim;
    c.lin = v[19:0];
    c.ang = omega[21:0];
    return c;
  endfunction

  assign pending = cmd_q.size();

  always @(posedge clk) begin
    drive_cmd_t exp_cmd;
    if (!rst_n) begin
      lin_gain <= LinGainRst;
      ang_gain <= AngGainRst;
      max_lin <= MaxLinRst;
      max_ang <= MaxAngRst;
      stop_dist <= StopDistRst;
      cmd_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LIN_GAIN: lin_gain <= cfg_data[20:0];
          REG_ANG_GAIN: ang_gain <= cfg_data;
          REG_MAX_LIN: max_lin <= cfg_data[19:0];
          REG_MAX_ANG: max_ang <= cfg_data[20:0];
          REG_STOP_DIST: stop_dist <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        cmd_q.push_back(drive_command(in_leader_x, in_leader_y, in_own_x, in_own_y,
                                      in_own_heading));
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result: lin=%0d ang=%0d", out_linear_speed,
                     out_angular_speed);
        end else begin
          exp_cmd = cmd_q.pop_front();
          if (exp_cmd.lin !== out_linear_speed || exp_cmd.ang !== out_angular_speed) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: lin exp %0d got %0d, ang exp %0d got %0d",
                       exp_cmd.lin, out_linear_speed, exp_cmd.ang, out_angular_speed);
          end
        end
      end
    end
  end
endmodule

FILE: tb/tb_go_to_goal_p_controller.sv
// Testbench top: clock, reset, requests, register settings and the verdict.
`timescale 1ns / 1ps
module tb_go_to_goal_p_controller import gtg_pkg::*;;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_leader_x;
  logic signed [31:0] in_leader_y;
  logic signed [31:0] in_own_x;
  logic signed [31:0] in_own_y;
  logic signed [18:0] in_own_heading;
  logic               out_valid;
  logic               out_ready;
  logic        [19:0] out_linear_speed;
  logic signed [21:0] out_angular_speed;
  logic               cfg_we;
  logic         [2:0] cfg_index;
  logic        [21:0] cfg_data;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  logic               no_idle;

  go_to_goal_p_controller i_dut (.*);
  go_to_goal_p_controller_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
  end

  task automatic send_pose(input logic signed [31:0] lx, input logic signed [31:0] ly,
                           input logic signed [31:0] ox, input logic signed [31:0] oy,
                           input logic signed [18:0] hd);
    if (!no_idle && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_leader_x <= lx;
    in_leader_y <= ly;
    in_own_x <= ox;
    in_own_y <= oy;
    in_own_heading <= hd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // all requests in flight must have drained before the gains change
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_gains(input logic [21:0] lg, input logic [21:0] ag,
                           input logic [21:0] ml, input logic [21:0] ma,
                           input logic [21:0] sd);
    logic [21:0] vals [5];
    reg_idx_t idx [5];
    vals = '{lg, ag, ml, ma, sd};
    idx = '{REG_LIN_GAIN, REG_ANG_GAIN, REG_MAX_LIN, REG_MAX_ANG, REG_STOP_DIST};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    // a write to an unlisted index must change nothing
    cfg_index <= RegUnused;
    cfg_data <= 22'h3fffff;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_poses(input int count);
    logic signed [31:0] ox, oy, lx, ly, off_x, off_y;
    logic signed [18:0] hd;
    int sh;
    for (int n = 0; n < count; n++) begin
      ox = $urandom;
      oy = $urandom;
      sh = $urandom_range(4, 24);
      off_x = $signed($urandom) >>> (31 - sh);
      off_y = $signed($urandom) >>> (31 - sh);
      case ($urandom_range(0, 9))
        0, 1: begin
          lx = $urandom;
          ly = $urandom;
        end
        2: begin
          lx = ox;
          ly = oy + off_y;
        end
        default: begin
          lx = ox + off_x;
          ly = oy + off_y;
        end
      endcase
      if ($urandom_range(0, 9) < 7) hd = 19'($urandom_range(0, 411774) - 205887);
      else hd = 19'($urandom);
      send_pose(lx, ly, ox, oy, hd);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_leader_x = '0;
    in_leader_y = '0;
    in_own_x = '0;
    in_own_y = '0;
    in_own_heading = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LIN_GAIN;
    cfg_data = '0;
    no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme positions, zero dx, heading corners
    send_pose(0, 0, 0, 0, 19'sd0);
    send_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 19'sd0);
    send_pose(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 19'sd0);
    send_pose(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 19'sd0);
    send_pose(5, 32'sh7fffffff, 5, 32'sh80000000, 19'sd0);
    send_pose(-7, 32'sh80000000, -7, 32'sh7fffffff, 19'sd0);
    send_pose(0, 1000, 0, 0, 19'sd100);
    send_pose(-65536, 3, 0, 0, 19'sd205887);
    send_pose(65536, -3, 0, 0, -19'sd205887);
    send_pose(1000, 2000, 0, 0, 19'sh40000);
    send_pose(1000, -2000, 0, 0, 19'sh3ffff);
    wait_idle();
    // deadband edge: distances straddle exactly one meter
    set_gains(22'd65536, 22'd393216, 22'd655360, 22'd186122, 22'd65536);
    for (int d = 65530; d < 65542; d++) send_pose(d, 0, 0, 0, 19'sd0);
    wait_idle();

    set_gains(22'd1048576, 22'd2097152, 22'd655360, 22'd1310720, 22'd655360);
    random_poses(340);
    wait_idle();
    set_gains(22'd0, 22'd0, 22'd0, 22'd0, 22'd0);
    random_poses(300);
    wait_idle();
    // over-wide values are masked to each register's width
    set_gains(22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff, 22'h3fffff);
    random_poses(300);
    wait_idle();
    no_idle = 1'b1;
    set_gains(22'($urandom_range(0, 1048576)), 22'($urandom_range(0, 2097152)),
              22'($urandom_range(0, 655360)), 22'($urandom_range(0, 1310720)),
              22'($urandom_range(0, 655360)));
    random_poses(340);
    wait_idle();
    no_idle = 1'b0;
    set_gains(22'(LinGainRst), AngGainRst, 22'(MaxLinRst), 22'(MaxAngRst),
              22'(StopDistRst));
    random_poses(400);
    wait_idle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: go_to_goal_p_controller.f
rtl/core/gtg_pkg.sv
rtl/core/go_to_goal_p_controller.sv
tb/go_to_goal_p_controller_checker.sv
tb/tb_go_to_goal_p_controller.sv
